@@ rtl/core/dcd_pkg.sv @@
// ----------------------------------------------------------------------------
// dcd_pkg
// Shared types and constants of the duplicate column detector: word formats,
// configuration register indexes, controller states and control structs.
// ----------------------------------------------------------------------------
package dcd_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int NUM_ROWS_W = 7;
  localparam int TOL_W      = 31;
  localparam int COL_NUM_W  = 5;
  localparam int DIFF_W     = 33;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_NUM_ROWS  = 2'd0;
  localparam cfg_idx_t CFG_TOLERANCE = 2'd1;

  typedef logic [COL_NUM_W-1:0] col_num_t;

  // missing against present counts as 1.0 in q16.16
  localparam logic signed [DIFF_W-1:0] DIFF_ONE  = 33'sd65536;
  localparam logic signed [DIFF_W-1:0] DIFF_ZERO = 33'sd0;

  typedef struct packed {
    logic signed [31:0] value;
    logic               missing;
    logic               first_of_matrix;
  } in_word_t;

  typedef struct packed {
    col_num_t column_number;
    col_num_t matched_column;
    logic     overflow;
  } out_word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } dcd_state_t;

  typedef struct packed {
    logic load;
    logic issue;
    logic commit;
  } dcd_cmd_t;

  typedef struct packed {
    logic issue_done;
    logic pipe_empty;
    logic col_end;
    logic out_free;
  } dcd_sts_t;

endpackage

@@ rtl/core/dcd_ctrl.sv @@
// ----------------------------------------------------------------------------
// dcd_ctrl
// Controller of the duplicate column detector: takes a word, steps the scan
// over the stored columns, waits for the compare pipeline and commits.
// ----------------------------------------------------------------------------
module dcd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  dcd_pkg::dcd_sts_t sts,
  output dcd_pkg::dcd_cmd_t cmd
);

  dcd_pkg::dcd_state_t state_r;
  dcd_pkg::dcd_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dcd_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    in_stall   = 1'b1;
    cmd.load   = 1'b0;
    cmd.issue  = 1'b0;
    cmd.commit = 1'b0;
    unique case (state_r)
      dcd_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = dcd_pkg::ST_SCAN;
        end
      end
      dcd_pkg::ST_SCAN: begin
        if (sts.issue_done) begin
          state_nxt = dcd_pkg::ST_DRAIN;
        end else begin
          cmd.issue = 1'b1;
        end
      end
      dcd_pkg::ST_DRAIN: begin
        if (sts.pipe_empty && (!sts.col_end || sts.out_free)) begin
          cmd.commit = 1'b1;
          state_nxt  = dcd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = dcd_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/core/dcd_datapath.sv @@
// ----------------------------------------------------------------------------
// dcd_datapath
// Datapath of the duplicate column detector: column store, row and column
// counters, match bits, pipelined difference compare and result register.
// ----------------------------------------------------------------------------
module dcd_datapath #(
  parameter int MAX_COLS = 16,
  parameter int MAX_ROWS = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  dcd_pkg::dcd_cmd_t                   cmd,
  output dcd_pkg::dcd_sts_t                   sts,
  input  dcd_pkg::in_word_t                   in_word,
  input  logic [dcd_pkg::NUM_ROWS_W-1:0]      num_rows,
  input  logic [dcd_pkg::TOL_W-1:0]           tolerance,
  input  logic                                out_stall,
  output logic                                out_valid,
  output dcd_pkg::out_word_t                  out_word
);

  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int EW    = (RW + 1 > dcd_pkg::NUM_ROWS_W) ? RW + 1 : dcd_pkg::NUM_ROWS_W;
  localparam int JW    = $clog2(MAX_COLS);
  localparam int CLW   = $clog2(MAX_COLS + 1);
  localparam int DEPTH = MAX_COLS * MAX_ROWS;
  localparam int AW    = $clog2(DEPTH);
  localparam int DW    = dcd_pkg::DIFF_W;

  logic signed [31:0]  item_value_r;
  logic                item_missing_r;
  logic [RW-1:0]       row_r;
  logic [CLW-1:0]      col_r;
  logic [MAX_COLS-1:0] match_r;
  logic [JW-1:0]       j_r;
  logic [AW-1:0]       addr_r;
  logic [JW:0]         found_r;

  logic [32:0]         store_r [DEPTH];
  logic [32:0]         rd_r;
  logic                v1_r;
  logic                v2_r;
  logic [JW-1:0]       j1_r;
  logic [JW-1:0]       j2_r;
  logic signed [DW-1:0] diff_r;

  logic                out_valid_r;
  dcd_pkg::out_word_t  out_word_r;

  logic                ovf;
  logic [EW-1:0]       rows_eff;
  logic [RW:0]         row_inc;
  logic                col_end;
  logic                out_free;
  logic [RW-1:0]       row_load;
  logic signed [DW-1:0] diff_nxt;
  logic signed [DW-1:0] tol_pos;
  logic signed [DW-1:0] tol_neg;
  logic                fail;
  logic                keep;

  assign ovf     = (col_r >= CLW'(MAX_COLS));
  assign row_inc = {1'b0, row_r} + 1'b1;
  assign col_end = (EW'(row_inc) >= rows_eff);
  assign out_free = !out_valid_r || !out_stall;
  assign row_load = in_word.first_of_matrix ? '0 : row_r;

  always_comb begin
    if (num_rows == '0) begin
      rows_eff = EW'(1);
    end else if (EW'(num_rows) > EW'(MAX_ROWS)) begin
      rows_eff = EW'(MAX_ROWS);
    end else begin
      rows_eff = EW'(num_rows);
    end
  end

  // difference of the new element against one stored element
  always_comb begin
    if (item_missing_r != rd_r[32]) begin
      diff_nxt = dcd_pkg::DIFF_ONE;
    end else if (item_missing_r) begin
      diff_nxt = dcd_pkg::DIFF_ZERO;
    end else begin
      diff_nxt = $signed({item_value_r[31], item_value_r}) - $signed({rd_r[31], rd_r[31:0]});
    end
  end

  assign tol_pos = $signed({2'b00, tolerance});
  assign tol_neg = -tol_pos;
  assign fail    = (diff_r >= tol_pos) || (diff_r <= tol_neg);
  assign keep    = match_r[j2_r] && !fail;

  assign sts.issue_done = ovf || (CLW'(j_r) == col_r);
  assign sts.pipe_empty = !v1_r && !v2_r;
  assign sts.col_end    = col_end;
  assign sts.out_free   = out_free;

  // column store
  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      rd_r <= store_r[addr_r];
    end
    if (cmd.commit && !ovf) begin
      store_r[addr_r] <= {item_missing_r, item_value_r};
    end
  end

  // compare pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= cmd.issue;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    j1_r   <= j_r;
    j2_r   <= j1_r;
    diff_r <= diff_nxt;
  end

  // item capture and scan address
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_value_r   <= in_word.value;
      item_missing_r <= in_word.missing;
      j_r            <= '0;
      addr_r         <= AW'(row_load);
    end else if (cmd.issue) begin
      j_r    <= j_r + 1'b1;
      addr_r <= addr_r + AW'(MAX_ROWS);
    end
  end

  // counters, match bits and lowest surviving column
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r   <= '0;
      col_r   <= '0;
      match_r <= '1;
      found_r <= '0;
    end else begin
      if (cmd.load) begin
        found_r <= '0;
        if (in_word.first_of_matrix) begin
          row_r   <= '0;
          col_r   <= '0;
          match_r <= '1;
        end
      end
      if (v2_r) begin
        match_r[j2_r] <= keep;
        if (keep && (found_r == '0)) begin
          found_r <= {1'b0, j2_r} + 1'b1;
        end
      end
      if (cmd.commit) begin
        if (col_end) begin
          row_r   <= '0;
          match_r <= '1;
          if (!ovf) begin
            col_r <= col_r + 1'b1;
          end
        end else begin
          row_r <= RW'(row_inc);
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.commit && col_end) begin
        out_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && col_end) begin
      if (ovf) begin
        out_word_r.column_number  <= '0;
        out_word_r.matched_column <= '0;
        out_word_r.overflow       <= 1'b1;
      end else begin
        out_word_r.column_number  <= dcd_pkg::col_num_t'(col_r + 1'b1);
        out_word_r.matched_column <= dcd_pkg::col_num_t'(found_r);
        out_word_r.overflow       <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

`ifndef SYNTHESIS
  a_commit_drained: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!v1_r && !v2_r))
    else $error("commit while compare pipeline busy");

  a_issue_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.issue |-> (!ovf && (CLW'(j_r) < col_r)))
    else $error("scan read beyond earlier columns");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && col_end) |=> out_valid_r)
    else $error("column end without result");

  a_col_saturate: assert property (@(posedge clk) disable iff (!rst_n)
    col_r <= CLW'(MAX_COLS))
    else $error("column counter past capacity");
`endif

endmodule

@@ rtl/core/duplicate_column_detector_unit.sv @@
// ----------------------------------------------------------------------------
// duplicate_column_detector_unit
// Flags each column of a column-major matrix stream that matches an earlier
// column within a tolerance, reporting the lowest matching column.
// ----------------------------------------------------------------------------
// One word is taken at a time. After a word is accepted, the single read
// port of the column store visits the earlier stored columns of the current
// matrix (at most MAX_COLS - 1 of them), one earlier column per cycle; then
// the scan ends, the controller waits for the last compare to leave the
// two-stage compare pipeline, and it commits before the next word is taken.
// Words with no earlier column to visit (first column of a matrix, or an
// overflow column) skip the visits. The result of a column is held in an
// output register, so a new word is taken while it waits; the commit of the
// next column end waits for that register to free.
// Configuration writes are always ready and take effect at once; write them
// only while the block is idle.
module duplicate_column_detector_unit #(
  parameter int MAX_COLS = 16,
  parameter int MAX_ROWS = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  dcd_pkg::in_word_t               in_word,
  output logic                            out_valid,
  input  logic                            out_stall,
  output dcd_pkg::out_word_t              out_word,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  dcd_pkg::cfg_idx_t               cfg_index,
  input  logic [dcd_pkg::TOL_W-1:0]       cfg_wdata
);

  logic [dcd_pkg::NUM_ROWS_W-1:0] num_rows_r;
  logic [dcd_pkg::TOL_W-1:0]      tolerance_r;

  dcd_pkg::dcd_cmd_t cmd;
  dcd_pkg::dcd_sts_t sts;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_rows_r  <= dcd_pkg::NUM_ROWS_W'(1);
      tolerance_r <= dcd_pkg::TOL_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        dcd_pkg::CFG_NUM_ROWS: begin
          num_rows_r <= cfg_wdata[dcd_pkg::NUM_ROWS_W-1:0];
        end
        dcd_pkg::CFG_TOLERANCE: begin
          tolerance_r <= cfg_wdata;
        end
        default: begin
        end
      endcase
    end
  end

  dcd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  dcd_datapath #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_word   (in_word),
    .num_rows  (num_rows_r),
    .tolerance (tolerance_r),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

endmodule

@@ dv/dcd_match_checker.sv @@
// ----------------------------------------------------------------------------
// dcd_match_checker
// Watches the element, report and register channels of the duplicate column
// detector. Keeps its own copy of the column store and match bits, predicts
// the report of each column completed by the accepted elements, and compares
// each accepted report with the oldest prediction. Hands the failure count
// and the number of reports still due to the testbench top.
// ----------------------------------------------------------------------------
module dcd_match_checker #(
  parameter int MAX_COLS = 16,
  parameter int MAX_ROWS = 64
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  dcd_pkg::in_word_t         in_word,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  dcd_pkg::out_word_t        out_word,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  dcd_pkg::cfg_idx_t         cfg_index,
  input  logic [dcd_pkg::TOL_W-1:0] cfg_wdata,
  output int unsigned               mismatches,
  output int unsigned               pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [dcd_pkg::NUM_ROWS_W-1:0] rows_reg;
  logic [dcd_pkg::TOL_W-1:0]      tol_reg;
  logic signed [31:0]             stored_value   [MAX_COLS*MAX_ROWS];
  logic                           stored_missing [MAX_COLS*MAX_ROWS];
  logic [MAX_COLS-1:0]            match_bits;
  int unsigned                    row_cnt;
  int unsigned                    col_cnt;
  int unsigned                    err_count;
  dcd_pkg::out_word_t             column_reports [$];

  initial begin
    mismatches = 0;
    pending    = 0;
  end

  function automatic longint row_gap(input logic signed [31:0] a, input logic ma,
                                     input logic signed [31:0] b, input logic mb);
    longint d;
    if (ma != mb) return 64'sd65536;
    if (ma) return 64'sd0;
    d = longint'(a) - longint'(b);
    return (d < 0) ? -d : d;
  endfunction

  function automatic bit take_element(input dcd_pkg::in_word_t w,
                                      output dcd_pkg::out_word_t rep);
    int unsigned rows;
    int unsigned col;
    int unsigned row;
    int unsigned a;
    bit          found;
    rep   = '0;
    found = 1'b0;
    if (rows_reg == 0) rows = 1;
    else if (rows_reg > MAX_ROWS) rows = MAX_ROWS;
    else rows = 32'(rows_reg);
    if (w.first_of_matrix) begin
      col_cnt    = 0;
      row_cnt    = 0;
      match_bits = '1;
    end
    col = col_cnt;
    row = (row_cnt >= MAX_ROWS) ? MAX_ROWS - 1 : row_cnt;
    if (col < MAX_COLS) begin
      for (int j = 0; j < col; j++) begin
        a = j * MAX_ROWS + row;
        if (match_bits[j] &&
            row_gap(w.value, w.missing, stored_value[a], stored_missing[a]) >=
            longint'(tol_reg))
          match_bits[j] = 1'b0;
      end
      stored_value[col*MAX_ROWS + row]   = w.value;
      stored_missing[col*MAX_ROWS + row] = w.missing;
    end
    row_cnt = row + 1;
    if (row_cnt < rows) return 1'b0;
    if (col < MAX_COLS) begin
      for (int j = 0; j < col; j++) begin
        if (match_bits[j] && !found) begin
          rep.matched_column = dcd_pkg::col_num_t'(j + 1);
          found = 1'b1;
        end
      end
      rep.column_number = dcd_pkg::col_num_t'(col + 1);
      col_cnt = col + 1;
    end else begin
      rep.overflow = 1'b1;
      col_cnt = MAX_COLS;
    end
    row_cnt    = 0;
    match_bits = '1;
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    dcd_pkg::out_word_t want;
    dcd_pkg::out_word_t report;
    if (!rst_n) begin
      rows_reg   = 7'd1;
      tol_reg    = 31'd1;
      row_cnt    = 0;
      col_cnt    = 0;
      match_bits = '1;
      err_count  = 0;
      column_reports.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          dcd_pkg::CFG_NUM_ROWS:  rows_reg = cfg_wdata[dcd_pkg::NUM_ROWS_W-1:0];
          dcd_pkg::CFG_TOLERANCE: tol_reg  = cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (column_reports.size() == 0) begin
          err_count++;
          $display("%0t: report word with none expected, got col %0d match %0d ovf %0b",
                   $time, out_word.column_number, out_word.matched_column,
                   out_word.overflow);
        end else begin
          want = column_reports.pop_front();
          if (out_word.column_number !== want.column_number ||
              out_word.matched_column !== want.matched_column ||
              out_word.overflow !== want.overflow) begin
            err_count++;
            $display("%0t: report mismatch, expected col %0d match %0d ovf %0b",
                     $time, want.column_number, want.matched_column, want.overflow);
            $display("%0t:                  actual   col %0d match %0d ovf %0b",
                     $time, out_word.column_number, out_word.matched_column,
                     out_word.overflow);
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (take_element(in_word, report)) column_reports.push_back(report);
      end
    end
    mismatches <= err_count;
    pending    <= column_reports.size();
  end

endmodule

@@ dv/duplicate_column_detector_unit_tb.sv @@
// ----------------------------------------------------------------------------
// duplicate_column_detector_unit_tb
// Streams matrices into the duplicate column detector: a short directed run
// over value extremes, missing elements, tolerance limits, row count limits,
// a mid-column row count change and dropped partial columns, then random
// matrices built from fresh, copied and slightly perturbed columns under
// several register settings and idle patterns, including a long report
// hold-off. The checker beside the block predicts and compares the reports.
// ----------------------------------------------------------------------------
module duplicate_column_detector_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_COLS       = 16;
  localparam int MAX_ROWS       = 64;
  localparam int RANDOM_ITEMS   = 750;
  localparam int PHASE_ITEMS    = 60;
  localparam int DRAIN_CYCLES   = 32;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 3000;

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_stall;
  dcd_pkg::in_word_t         in_word;
  logic                      out_valid;
  logic                      out_stall;
  dcd_pkg::out_word_t        out_word;
  logic                      cfg_valid;
  logic                      cfg_ready;
  dcd_pkg::cfg_idx_t         cfg_index;
  logic [dcd_pkg::TOL_W-1:0] cfg_wdata;
  int unsigned               mismatches;
  int unsigned               pending;

  int unsigned        send_pct;
  int unsigned        stall_pct;
  int unsigned        hold_requests;
  int unsigned        hold_served;
  int unsigned        item_count;
  int unsigned        quiet_cycles;
  logic signed [31:0] mat_value   [20][MAX_ROWS];
  logic               mat_missing [20][MAX_ROWS];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  duplicate_column_detector_unit #(
    .MAX_COLS(MAX_COLS),
    .MAX_ROWS(MAX_ROWS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  dcd_match_checker #(
    .MAX_COLS(MAX_COLS),
    .MAX_ROWS(MAX_ROWS)
  ) checker_i (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .mismatches(mismatches),
    .pending   (pending)
  );

  // report side: random stalls, plus a long hold-off on request
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_served != hold_requests) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_served++;
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_word(input logic signed [31:0] v, input logic m, input logic f);
    dcd_pkg::in_word_t w;
    w.value           = v;
    w.missing         = m;
    w.first_of_matrix = f;
    while ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    item_count++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_regs(input logic [dcd_pkg::NUM_ROWS_W-1:0] rows,
                          input logic [dcd_pkg::TOL_W-1:0] tol);
    cfg_valid <= 1'b1;
    cfg_index <= dcd_pkg::CFG_NUM_ROWS;
    cfg_wdata <= dcd_pkg::TOL_W'(rows);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= dcd_pkg::CFG_TOLERANCE;
    cfg_wdata <= tol;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [dcd_pkg::NUM_ROWS_W-1:0] pick_rows();
    case ($urandom_range(19))
      0:       return 7'd0;
      1:       return 7'($urandom_range(65, 127));
      2:       return 7'd64;
      3, 4, 5: return 7'($urandom_range(5, 16));
      default: return 7'($urandom_range(1, 4));
    endcase
  endfunction

  function automatic logic [dcd_pkg::TOL_W-1:0] pick_tol();
    case ($urandom_range(9))
      0:       return 31'd0;
      1:       return 31'd1;
      2:       return 31'h7fff_ffff;
      3:       return 31'd65536;
      4:       return 31'd65537;
      5:       return 31'($urandom);
      default: return 31'($urandom_range(2, 5000));
    endcase
  endfunction

  // fresh, copied, perturbed and missing-flipped columns, then an optional
  // partial column that the next matrix drops
  task automatic send_matrix(input int unsigned rows, input int unsigned ncols,
                             input logic [dcd_pkg::TOL_W-1:0] tol);
    int unsigned        src;
    int unsigned        kind;
    int unsigned        r;
    logic signed [31:0] delta;
    for (int c = 0; c < ncols; c++) begin
      src  = (c > 0) ? $urandom_range(c - 1) : 0;
      kind = (c > 0) ? $urandom_range(9) : $urandom_range(4);
      for (int k = 0; k < rows; k++) begin
        if (kind <= 3) begin
          mat_value[c][k]   = $urandom;
          mat_missing[c][k] = ($urandom_range(15) == 0);
        end else if (kind == 4) begin
          mat_value[c][k]   = 32'sd1 - 32'($urandom_range(2));
          mat_missing[c][k] = ($urandom_range(3) == 0);
        end else begin
          mat_value[c][k]   = mat_value[src][k];
          mat_missing[c][k] = mat_missing[src][k];
        end
      end
      r = $urandom_range(rows - 1);
      if (kind == 6 || kind == 7) begin
        case ($urandom_range(3))
          0:       delta = 32'(tol) - 1;
          1:       delta = 32'(tol);
          2:       delta = 32'(tol) + 1;
          default: delta = 32'($urandom_range(3));
        endcase
        if ($urandom_range(1)) mat_value[c][r] = mat_value[c][r] + delta;
        else mat_value[c][r] = mat_value[c][r] - delta;
      end else if (kind == 8) begin
        mat_missing[c][r] = !mat_missing[c][r];
      end
      for (int k = 0; k < rows; k++)
        send_word(mat_value[c][k], mat_missing[c][k], (c == 0 && k == 0));
    end
    if (rows > 1 && $urandom_range(7) == 0) begin
      repeat ($urandom_range(1, rows - 1))
        send_word($urandom, 1'($urandom_range(1)), 1'b0);
    end
  endtask

  initial begin
    logic [dcd_pkg::NUM_ROWS_W-1:0] rows_sel;
    logic [dcd_pkg::TOL_W-1:0]      tol_sel;
    int unsigned                    eff_rows;
    int unsigned                    ncols;
    int unsigned                    phase;
    int unsigned                    phase_start;
    int unsigned                    random_start;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_word       <= '0;
    cfg_valid     <= 1'b0;
    cfg_index     <= dcd_pkg::CFG_NUM_ROWS;
    cfg_wdata     <= '0;
    send_pct      = 0;
    stall_pct     = 0;
    hold_requests = 0;
    hold_served   = 0;
    item_count    = 0;
    quiet_cycles  = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: one row per column, exact equality
    send_word(32'sh8000_0000, 1'b0, 1'b1);
    send_word(32'sh7fff_ffff, 1'b0, 1'b0);
    send_word(32'sh8000_0000, 1'b0, 1'b0);
    send_word(32'sh0000_1234, 1'b1, 1'b0);
    send_word(32'shffff_0000, 1'b1, 1'b0);
    send_word(32'sh0000_0000, 1'b0, 1'b0);
    settle();
    // zero tolerance never matches
    set_regs(7'd1, 31'd0);
    repeat (3) send_word(32'sh0000_0000, 1'b0, (item_count == 6));
    settle();
    // zero row count acts as one, widest tolerance
    set_regs(7'd0, 31'h7fff_ffff);
    send_word(32'sh7fff_ffff, 1'b0, 1'b1);
    send_word(32'sh8000_0000, 1'b0, 1'b0);
    send_word(32'sh0000_0000, 1'b1, 1'b0);
    settle();
    // row count lowered mid-column, then a dropped partial column
    set_regs(7'd3, 31'd65537);
    send_word(32'sd5, 1'b0, 1'b1);
    send_word(32'sd0, 1'b1, 1'b0);
    send_word(-32'sd3, 1'b0, 1'b0);
    send_word(32'sd5, 1'b0, 1'b0);
    send_word(32'sd9, 1'b1, 1'b0);
    settle();
    set_regs(7'd2, 31'd65537);
    send_word(32'sd65533, 1'b0, 1'b0);
    send_word(32'sd65542, 1'b0, 1'b0);
    send_word(32'sd0, 1'b1, 1'b0);
    send_word(32'sd1, 1'b0, 1'b0);
    send_word(32'sd1, 1'b0, 1'b1);
    send_word(32'sd2, 1'b0, 1'b0);
    settle();

    phase        = 0;
    random_start = item_count;
    while (item_count - random_start < RANDOM_ITEMS) begin
      case (phase % 4)
        0: begin send_pct = 0;  stall_pct = 0;  end
        1: begin send_pct = 54; stall_pct = 0;  end
        2: begin send_pct = 0;  stall_pct = 54; end
        default: begin send_pct = 15; stall_pct = 15; end
      endcase
      rows_sel = pick_rows();
      tol_sel  = pick_tol();
      if (phase == 1) begin
        rows_sel = 7'd127;
        tol_sel  = 31'd65536;
      end
      if (phase == 4) begin
        rows_sel  = 7'd1;
        send_pct  = 0;
        stall_pct = 0;
        hold_requests++;
      end
      set_regs(rows_sel, tol_sel);
      if (rows_sel == 0) eff_rows = 1;
      else if (rows_sel > MAX_ROWS) eff_rows = MAX_ROWS;
      else eff_rows = 32'(rows_sel);
      phase_start = item_count;
      while (item_count - phase_start < PHASE_ITEMS) begin
        if (eff_rows > 16) ncols = 2;
        else if (eff_rows > 4) ncols = $urandom_range(2, 5);
        else if ($urandom_range(4) == 0) ncols = $urandom_range(16, 18);
        else ncols = $urandom_range(2, 8);
        send_matrix(eff_rows, ncols, tol_sel);
      end
      settle();
      phase++;
    end

    if (mismatches == 0 && pending == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
